[hdl/afda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afda_pkg
// Shared types and constants for the aspect fit/fill draw-area block.
// ----------------------------------------------------------------------------
package afda_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIM_BITS   = 31;
    localparam int PROD_BITS  = 2 * DIM_BITS;
    localparam int CMD_BITS   = 2;

    localparam logic [CMD_BITS-1:0] CMD_STRETCH = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_FIT     = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FILL    = 2'd2;

    localparam logic [DIM_BITS-1:0] SCALE_MAX =
        DIM_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);

    typedef struct packed {
        logic                        valid;
        logic signed [31:0]          x;
        logic signed [31:0]          y;
        logic [DIM_BITS-1:0]         w;
        logic [DIM_BITS-1:0]         h;
        logic [DIM_BITS-1:0]         aw;
        logic [DIM_BITS-1:0]         ah;
        logic                        scale;
        logic                        on_x;
        logic                        neg;
    } afda_ctl_t;

endpackage

[hdl/aspect_fit_fill_draw_area.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspect_fit_fill_draw_area
// Aspect fit/fill adjustment of a draw area over a row of divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the request fields for one cycle per beat; busy is held
//   low, so a beat is taken every cycle. Each request yields one result,
//   shown for a single cycle with done high on origin_x_out, origin_y_out,
//   draw_width and draw_height.
//   The path runs through two front stages (cross products, scale product),
//   31 divider cells that each settle one quotient bit and pass it on, and
//   one output register. Throughput is one beat per cycle, set by the cell
//   row: every cell works on a different request.
//   Reset clears all valid flags; nothing is in flight afterward.
//   The receiver cannot stall; results are presented in request order.
// ----------------------------------------------------------------------------
module aspect_fit_fill_draw_area (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [31:0]            src_width,
    input  logic signed [31:0]            src_height,
    input  logic signed [31:0]            origin_x_in,
    input  logic signed [31:0]            origin_y_in,
    input  logic signed [31:0]            area_width,
    input  logic signed [31:0]            area_height,
    input  logic [afda_pkg::CMD_BITS-1:0] command,
    output logic                          done,
    output logic signed [31:0]            origin_x_out,
    output logic signed [31:0]            origin_y_out,
    output logic [afda_pkg::DIM_BITS-1:0] draw_width,
    output logic [afda_pkg::DIM_BITS-1:0] draw_height
);
    import afda_pkg::*;

    localparam int NCELL = DIM_BITS;

    afda_ctl_t            ctl   [NCELL+1];
    logic [PROD_BITS-1:0] rem   [NCELL+1];
    logic [PROD_BITS-1:0] quo   [NCELL+1];
    logic [DIM_BITS-1:0]  dvs   [NCELL+1];
    logic [DIM_BITS-1:0]  iw_sh [NCELL+3];
    logic [DIM_BITS-1:0]  ih_sh [NCELL+3];

    assign busy   = 1'b0;
    assign quo[0] = '0;

    afda_front u_front (
        .clk, .rst_n, .start,
        .src_width, .src_height, .origin_x_in, .origin_y_in,
        .area_width, .area_height, .command,
        .ctl_out  (ctl[0]),
        .prod_out (rem[0]),
        .dvs_out  (dvs[0])
    );

    // image size travels alongside for the out-of-range fallback
    assign iw_sh[0] = src_width[DIM_BITS-1:0];
    assign ih_sh[0] = src_height[DIM_BITS-1:0];
    for (genvar g = 0; g < NCELL + 2; g++)
    begin : g_img
        always_ff @(posedge clk)
        begin
            iw_sh[g+1] <= iw_sh[g];
            ih_sh[g+1] <= ih_sh[g];
        end
    end

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        afda_div_cell u_cell (
            .clk, .rst_n,
            .ctl_in  (ctl[g]),
            .rem_in  (rem[g]),
            .quo_in  (quo[g]),
            .dvs_in  (dvs[g]),
            .shift   (6'(PROD_BITS - 1 - g - (PROD_BITS - NCELL))),
            .ctl_out (ctl[g+1]),
            .rem_out (rem[g+1]),
            .quo_out (quo[g+1]),
            .dvs_out (dvs[g+1])
        );
    end

    // a remainder left at or above the divisor flags a quotient past DIM_BITS
    logic [PROD_BITS-1:0] quo_fix;
    always_comb
    begin
        quo_fix = quo[NCELL];
        if (rem[NCELL] >= {{DIM_BITS{1'b0}}, dvs[NCELL]})
            quo_fix = {PROD_BITS{1'b1}};
    end

    afda_back u_back (
        .clk, .rst_n,
        .ctl_in  (ctl[NCELL]),
        .quo_in  (quo_fix),
        .iw_in   (iw_sh[NCELL+2]),
        .ih_in   (ih_sh[NCELL+2]),
        .done, .origin_x_out, .origin_y_out, .draw_width, .draw_height
    );

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NCELL + 3) done)
        else $error("result missing");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NCELL + 3))
        else $error("result without request");
endmodule

[hdl/afda_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afda_div_cell
// One restoring-division step: one quotient bit per cycle, passed down the row.
// ----------------------------------------------------------------------------
module afda_div_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  afda_pkg::afda_ctl_t          ctl_in,
    input  logic [afda_pkg::PROD_BITS-1:0] rem_in,
    input  logic [afda_pkg::PROD_BITS-1:0] quo_in,
    input  logic [afda_pkg::DIM_BITS-1:0]  dvs_in,
    input  logic [5:0]                   shift,
    output afda_pkg::afda_ctl_t          ctl_out,
    output logic [afda_pkg::PROD_BITS-1:0] rem_out,
    output logic [afda_pkg::PROD_BITS-1:0] quo_out,
    output logic [afda_pkg::DIM_BITS-1:0]  dvs_out
);
    import afda_pkg::*;

    logic [PROD_BITS+DIM_BITS-1:0] trial;
    logic                          take;
    logic [PROD_BITS-1:0]          sub;
    logic                          valid_reg;
    afda_ctl_t                     ctl_reg;
    logic [PROD_BITS-1:0]          rem_reg;
    logic [PROD_BITS-1:0]          quo_reg;
    logic [DIM_BITS-1:0]           dvs_reg;

    always_comb
    begin
        trial = {{DIM_BITS{1'b0}}, dvs_in} << shift;
        take  = ctl_in.scale && ({{DIM_BITS{1'b0}}, rem_in} >= trial);
        sub   = rem_in - trial[PROD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_in;
        dvs_reg <= dvs_in;
        rem_reg <= take ? sub : rem_in;
        quo_reg <= quo_in | (take ? (PROD_BITS'(1) << shift) : '0);
    end

    always_comb
    begin
        ctl_out       = ctl_reg;
        ctl_out.valid = valid_reg;
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dvs_out = dvs_reg;
endmodule

[hdl/afda_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afda_front
// Decode cases, compare aspect ratios, form the scale product.
// ----------------------------------------------------------------------------
module afda_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [31:0]             src_width,
    input  logic signed [31:0]             src_height,
    input  logic signed [31:0]             origin_x_in,
    input  logic signed [31:0]             origin_y_in,
    input  logic signed [31:0]             area_width,
    input  logic signed [31:0]             area_height,
    input  logic [afda_pkg::CMD_BITS-1:0]  command,
    output afda_pkg::afda_ctl_t            ctl_out,
    output logic [afda_pkg::PROD_BITS-1:0] prod_out,
    output logic [afda_pkg::DIM_BITS-1:0]  dvs_out
);
    import afda_pkg::*;

    // stage 1: cross products
    logic                  v1_reg;
    afda_ctl_t             c1_reg;
    logic [PROD_BITS-1:0]  p1_reg;
    logic [PROD_BITS-1:0]  p2_reg;
    logic [DIM_BITS-1:0]   iw1_reg;
    logic [DIM_BITS-1:0]   ih1_reg;
    logic                  fill1_reg;
    // stage 2: scale product
    logic                  v2_reg;
    afda_ctl_t             c2_reg;
    afda_ctl_t             c2_next;
    logic [PROD_BITS-1:0]  pr2_reg;
    logic [DIM_BITS-1:0]   dv2_reg;
    afda_ctl_t             c1_next;
    logic                  img_bad;
    logic                  area_bad;
    logic                  fill;
    logic                  wider;
    logic                  use_w;
    logic [DIM_BITS-1:0]   ma;
    logic [DIM_BITS-1:0]   mb;

    always_comb
    begin
        img_bad  = (src_width <= 0) || (src_height <= 0);
        area_bad = (area_width <= 0) || (area_height <= 0);
        fill     = (command == CMD_FILL);
        c1_next       = '0;
        c1_next.x     = origin_x_in;
        c1_next.y     = origin_y_in;
        c1_next.aw    = area_width[DIM_BITS-1:0];
        c1_next.ah    = area_height[DIM_BITS-1:0];
        priority if (img_bad)
        begin
            c1_next.w = '0;
            c1_next.h = '0;
        end
        else if (area_bad)
        begin
            c1_next.w = src_width[DIM_BITS-1:0];
            c1_next.h = src_height[DIM_BITS-1:0];
        end
        else
        begin
            c1_next.w     = area_width[DIM_BITS-1:0];
            c1_next.h     = area_height[DIM_BITS-1:0];
            c1_next.scale = (command == CMD_FIT) || fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg    <= c1_next;
        fill1_reg <= fill;
        iw1_reg   <= src_width[DIM_BITS-1:0];
        ih1_reg   <= src_height[DIM_BITS-1:0];
        p1_reg    <= src_width[DIM_BITS-1:0] * area_height[DIM_BITS-1:0];
        p2_reg    <= area_width[DIM_BITS-1:0] * src_height[DIM_BITS-1:0];
    end

    always_comb
    begin
        wider = p1_reg > p2_reg;
        use_w = (fill1_reg == wider);
        ma    = use_w ? iw1_reg : ih1_reg;
        mb    = use_w ? c1_reg.ah : c1_reg.aw;
        c2_next      = c1_reg;
        c2_next.on_x = use_w;
        c2_next.neg  = fill1_reg;
    end

    always_ff @(posedge clk)
    begin
        c2_reg      <= c2_next;
        pr2_reg     <= ma * mb;
        dv2_reg     <= use_w ? ih1_reg : iw1_reg;
    end

    always_comb
    begin
        ctl_out       = c2_reg;
        ctl_out.valid = v2_reg;
    end

    assign prod_out = pr2_reg;
    assign dvs_out  = dv2_reg;
endmodule

[hdl/afda_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afda_back
// Range-check the quotient, center and saturate the origin, register result.
// ----------------------------------------------------------------------------
module afda_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  afda_pkg::afda_ctl_t            ctl_in,
    input  logic [afda_pkg::PROD_BITS-1:0] quo_in,
    input  logic [afda_pkg::DIM_BITS-1:0]  iw_in,
    input  logic [afda_pkg::DIM_BITS-1:0]  ih_in,
    output logic                           done,
    output logic signed [31:0]             origin_x_out,
    output logic signed [31:0]             origin_y_out,
    output logic [afda_pkg::DIM_BITS-1:0]  draw_width,
    output logic [afda_pkg::DIM_BITS-1:0]  draw_height
);
    import afda_pkg::*;

    localparam logic signed [33:0] C_MAX = 34'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [33:0] C_MIN = -C_MAX - 34'sd1;

    logic                  ok;
    logic [DIM_BITS-1:0]   s;
    logic signed [33:0]    diff;
    logic signed [33:0]    half;
    logic signed [33:0]    base;
    logic signed [33:0]    sum;
    logic signed [31:0]    sat;
    logic                  done_reg;
    logic signed [31:0]    x_reg;
    logic signed [31:0]    y_reg;
    logic [DIM_BITS-1:0]   w_reg;
    logic [DIM_BITS-1:0]   h_reg;
    logic signed [31:0]    x_next;
    logic signed [31:0]    y_next;
    logic [DIM_BITS-1:0]   w_next;
    logic [DIM_BITS-1:0]   h_next;

    always_comb
    begin
        s    = quo_in[DIM_BITS-1:0];
        ok   = (quo_in != '0) && (quo_in <= PROD_BITS'(SCALE_MAX));
        diff = ctl_in.on_x ? (34'($signed({1'b0, s})) - 34'($signed({1'b0, ctl_in.aw})))
                           : (34'($signed({1'b0, s})) - 34'($signed({1'b0, ctl_in.ah})));
        if (!ctl_in.neg)
            diff = -diff;
        half = (diff < 0) ? -((-diff) >>> 1) : (diff >>> 1);
        if (ctl_in.neg)
            half = -half;
        base = ctl_in.on_x ? 34'(ctl_in.x) : 34'(ctl_in.y);
        sum  = base + half;
        if (sum > C_MAX)
            sat = 32'(C_MAX);
        else if (sum < C_MIN)
            sat = 32'(C_MIN);
        else
            sat = 32'(sum);
        x_next = ctl_in.x;
        y_next = ctl_in.y;
        w_next = ctl_in.w;
        h_next = ctl_in.h;
        if (ctl_in.scale)
        begin
            if (!ok)
            begin
                w_next = iw_in;
                h_next = ih_in;
            end
            else if (ctl_in.on_x)
            begin
                x_next = sat;
                w_next = s;
            end
            else
            begin
                y_next = sat;
                h_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        w_reg <= w_next;
        h_reg <= h_next;
    end

    assign done         = done_reg;
    assign origin_x_out = x_reg;
    assign origin_y_out = y_reg;
    assign draw_width   = w_reg;
    assign draw_height  = h_reg;
endmodule

[sim/tb_aspect_fit_fill_draw_area.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aspect_fit_fill_draw_area
// Self-checking bench for the aspect fit/fill block. A directed table covers
// invalid images, empty areas, every command, scale limits and origin
// saturation, then about 900 random requests follow under three idle profiles.
// Every result is compared field by field to a table entry or a local predictor.
// ----------------------------------------------------------------------------
module tb_aspect_fit_fill_draw_area;
    import afda_pkg::*;

    localparam int  LATENCY   = 34;
    localparam int  N_RANDOM  = 900;
    localparam longint CYCLE_LIMIT = 200000;
    localparam longint C_MAX = 64'sd2147483647;
    localparam longint C_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0]  iw;
        logic signed [31:0]  ih;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic signed [31:0]  aw;
        logic signed [31:0]  ah;
        logic [CMD_BITS-1:0] cmd;
    } request_t;

    typedef struct packed {
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } area_t;

    typedef struct packed {
        request_t req;
        logic     fixed;
        area_t    want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [31:0]   src_width;
    logic signed [31:0]   src_height;
    logic signed [31:0]   origin_x_in;
    logic signed [31:0]   origin_y_in;
    logic signed [31:0]   area_width;
    logic signed [31:0]   area_height;
    logic [CMD_BITS-1:0]  command;
    logic                 done;
    logic signed [31:0]   origin_x_out;
    logic signed [31:0]   origin_y_out;
    logic [DIM_BITS-1:0]  draw_width;
    logic [DIM_BITS-1:0]  draw_height;

    area_t  pending_areas[$];
    int     mismatches;
    longint cycles;
    int     send_idle_pct;

    aspect_fit_fill_draw_area u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .src_width    (src_width),
        .src_height   (src_height),
        .origin_x_in  (origin_x_in),
        .origin_y_in  (origin_y_in),
        .area_width   (area_width),
        .area_height  (area_height),
        .command      (command),
        .done         (done),
        .origin_x_out (origin_x_out),
        .origin_y_out (origin_y_out),
        .draw_width   (draw_width),
        .draw_height  (draw_height)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit scaled(input longint a, input longint b, input longint c,
                                  output longint s);
        if (a <= 0 || b <= 0 || c <= 0)
            return 1'b0;
        s = (a * b) / c;
        return (s > 0 && s <= C_MAX);
    endfunction

    function automatic longint clamp_origin(input longint c, input longint off);
        longint r;
        r = c + off;
        if (r < C_MIN)
            return C_MIN;
        if (r > C_MAX)
            return C_MAX;
        return r;
    endfunction

    function automatic area_t fit_fill_area(input request_t r);
        longint iw, ih, x, y, aw, ah, w, h, s;
        bit     wider;
        bit     ok;
        area_t  a;
        iw = r.iw;
        ih = r.ih;
        x  = r.x;
        y  = r.y;
        aw = r.aw;
        ah = r.ah;
        if (iw <= 0 || ih <= 0) begin
            w = 0;
            h = 0;
        end else if (aw <= 0 || ah <= 0) begin
            w = iw;
            h = ih;
        end else if (r.cmd == CMD_FILL || r.cmd == CMD_FIT) begin
            wider = (iw * ah) > (aw * ih);
            w = aw;
            h = ah;
            if ((r.cmd == CMD_FILL) == wider) begin
                ok = scaled(iw, ah, ih, s);
                if (!ok) begin
                    w = iw;
                    h = ih;
                end else begin
                    x = clamp_origin(x, (r.cmd == CMD_FILL) ? -((s - aw) / 2) : (aw - s) / 2);
                    w = s;
                end
            end else begin
                ok = scaled(ih, aw, iw, s);
                if (!ok) begin
                    w = iw;
                    h = ih;
                end else begin
                    y = clamp_origin(y, (r.cmd == CMD_FILL) ? -((s - ah) / 2) : (ah - s) / 2);
                    h = s;
                end
            end
        end else begin
            w = aw;
            h = ah;
        end
        a.x = x[31:0];
        a.y = y[31:0];
        a.w = w[DIM_BITS-1:0];
        a.h = h[DIM_BITS-1:0];
        return a;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // check results at each edge
    always @(posedge clk)
    begin
        area_t e;
        if (rst_n && done) begin
            if (pending_areas.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                e = pending_areas.pop_front();
                if (origin_x_out !== e.x) report("origin_x_out", origin_x_out, e.x);
                if (origin_y_out !== e.y) report("origin_y_out", origin_y_out, e.y);
                if (draw_width !== e.w)   report("draw_width", draw_width, e.w);
                if (draw_height !== e.h)  report("draw_height", draw_height, e.h);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return -$signed(32'($urandom_range(0, 5)));
            2:       return 32'($urandom_range(1, 3));
            3, 4:    return 32'($urandom_range(1, 65535));
            5:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            6:       return 32'($urandom_range(1, 32'h7FFF_FFFF));
            default: return 32'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_origin();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 1000));
            1:       return 32'h8000_0000 + 32'($urandom_range(0, 1000));
            2:       return $urandom;
            default: return $signed(32'($urandom_range(0, 8000))) - 4000;
        endcase
    endfunction

    // drive one beat; hold start while busy
    task automatic send(input request_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        src_width    <= r.iw;
        src_height   <= r.ih;
        origin_x_in  <= r.x;
        origin_y_in  <= r.y;
        area_width   <= r.aw;
        area_height  <= r.ah;
        command      <= r.cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic row_t row(input request_t r, input bit fixed, input area_t want);
        row_t t;
        t.req = r;
        t.fixed = fixed;
        t.want = want;
        return t;
    endfunction

    initial
    begin
        row_t     rows[$];
        request_t r;
        area_t    a;
        area_t    z;
        int       phase;
        int       n;
        int       wait_cycles;
        z = '0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        src_width = '0;
        src_height = '0;
        origin_x_in = '0;
        origin_y_in = '0;
        area_width = '0;
        area_height = '0;
        command = CMD_STRETCH;

        rows.push_back(row('{0, 10, 5, 6, 20, 20, CMD_FIT}, 1, '{5, 6, 0, 0}));
        rows.push_back(row('{10, -1, 5, 6, 20, 20, CMD_FILL}, 1, '{5, 6, 0, 0}));
        rows.push_back(row('{32'h8000_0000, 32'h8000_0000, -1, -1, 1, 1, CMD_FIT},
                           1, '{-1, -1, 0, 0}));
        rows.push_back(row('{10, 20, 7, 8, 0, 30, CMD_FIT}, 1, '{7, 8, 10, 20}));
        rows.push_back(row('{10, 20, 7, 8, 30, -5, CMD_FILL}, 1, '{7, 8, 10, 20}));
        rows.push_back(row('{10, 20, 7, 8, 30, 40, CMD_STRETCH}, 1, '{7, 8, 30, 40}));
        rows.push_back(row('{10, 20, 7, 8, 30, 40, 2'd3}, 1, '{7, 8, 30, 40}));
        rows.push_back(row('{200, 100, 0, 0, 100, 100, CMD_FIT}, 0, z));
        rows.push_back(row('{200, 100, 0, 0, 100, 100, CMD_FILL}, 0, z));
        rows.push_back(row('{100, 200, 0, 0, 100, 100, CMD_FIT}, 0, z));
        rows.push_back(row('{100, 200, 0, 0, 100, 100, CMD_FILL}, 0, z));
        rows.push_back(row('{64, 64, 3, 4, 32, 32, CMD_FIT}, 0, z));
        rows.push_back(row('{101, 50, 0, 0, 100, 50, CMD_FILL}, 0, z));
        rows.push_back(row('{1, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1, CMD_FIT}, 0, z));
        rows.push_back(row('{32'h7FFF_FFFF, 1, 0, 0, 1, 32'h7FFF_FFFF, CMD_FILL}, 0, z));
        rows.push_back(row('{32'h7FFF_FFFF, 1, 32'h8000_0000, 0, 1000, 1000, CMD_FILL},
                           0, z));
        rows.push_back(row('{1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1000, 1000, CMD_FILL},
                           0, z));
        rows.push_back(row('{1000, 1, 0, 32'h7FFF_FFFF, 10, 32'h7FFF_FFFF, CMD_FIT}, 0, z));
        rows.push_back(row('{1, 1000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 10, CMD_FIT}, 0, z));
        rows.push_back(row('{32'h7FFF_FFFF, 32'h7FFF_FFFF, -3, 3,
                             32'h7FFF_FFFF, 32'h7FFF_FFFE, CMD_FILL}, 0, z));
        rows.push_back(row('{3, 2, 1, 1, 2, 3, CMD_FIT}, 0, z));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            a = fit_fill_area(rows[i].req);
            pending_areas.push_back(rows[i].fixed ? rows[i].want : a);
            send(rows[i].req);
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 71 : 0;
            for (n = 0; n < N_RANDOM / 3; n++) begin
                r.iw  = rand_dim();
                r.ih  = rand_dim();
                r.x   = rand_origin();
                r.y   = rand_origin();
                r.aw  = rand_dim();
                r.ah  = rand_dim();
                r.cmd = ($urandom_range(0, 9) == 0) ? CMD_BITS'($urandom_range(0, 3))
                                                    : ($urandom_range(0, 1) ? CMD_FIT : CMD_FILL);
                pending_areas.push_back(fit_fill_area(r));
                send(r);
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_areas.size() != 0 && wait_cycles < 100 * LATENCY) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatches == 0 && pending_areas.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (pending_areas.size() != 0)
                report("results missing", pending_areas.size(), 0);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
